>>> sv/esm_pkg.sv
`default_nettype none

package esm_pkg;

   localparam int SUM_W      = 32;
   localparam int LUMA_W     = 8;
   localparam int CHAN_W     = 8;
   localparam int MEAN_W     = 16;
   localparam int FRAC_W     = 8;
   localparam int FILL_OUT_W = 8;
   localparam int LUMA_ACC_W = 22;
   localparam int LUMA_SHIFT = 14;

   localparam logic [LUMA_ACC_W-1:0] LUMA_B_COEF = 22'd1868;
   localparam logic [LUMA_ACC_W-1:0] LUMA_G_COEF = 22'd9617;
   localparam logic [LUMA_ACC_W-1:0] LUMA_R_COEF = 22'd4899;
   localparam logic [LUMA_ACC_W-1:0] LUMA_ROUND  = 22'd8192;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_LENGTH   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_SAMPLES     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RANGE_THRESHOLD = 2'd2;

   localparam logic [7:0]  WINDOW_LENGTH_RESET   = 8'd90;
   localparam logic [7:0]  MIN_SAMPLES_RESET     = 8'd30;
   localparam logic [15:0] RANGE_THRESHOLD_RESET = 16'd6400;

   typedef struct packed {
      logic [7:0]  window_length;
      logic [7:0]  min_samples;
      logic [15:0] range_threshold;
   } csr_type;

   function automatic logic [LUMA_W-1:0] luma_of(input logic [CHAN_W-1:0] b,
                                                 input logic [CHAN_W-1:0] g,
                                                 input logic [CHAN_W-1:0] r);
      logic [LUMA_ACC_W-1:0] acc;
      acc = LUMA_B_COEF * LUMA_ACC_W'(b) + LUMA_G_COEF * LUMA_ACC_W'(g)
          + LUMA_R_COEF * LUMA_ACC_W'(r) + LUMA_ROUND;
      return acc[LUMA_SHIFT +: LUMA_W];
   endfunction

endpackage

`default_nettype wire

>>> sv/esm_pixel_if.sv
`default_nettype none

interface esm_pixel_if;
   logic       valid;
   logic       ready;
   logic [7:0] blue;
   logic [7:0] green;
   logic [7:0] red;
   logic       last_pixel;

   modport source(output valid, blue, green, red, last_pixel, input ready);
   modport sink(input valid, blue, green, red, last_pixel, output ready);
endinterface

`default_nettype wire

>>> sv/esm_result_if.sv
`default_nettype none

interface esm_result_if;
   logic        valid;
   logic        ready;
   logic [15:0] mean_luma;
   logic        adjusting;
   logic [7:0]  window_fill;

   modport source(output valid, mean_luma, adjusting, window_fill, input ready);
   modport sink(input valid, mean_luma, adjusting, window_fill, output ready);
endinterface

`default_nettype wire

>>> sv/esm_ram.sv
`default_nettype none

module esm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> sv/esm_queue.sv
`default_nettype none

module esm_queue #(
   parameter int WIDTH = 56,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   output      logic             in_ready,
   input  wire logic [WIDTH-1:0] in_data,
   output      logic             out_valid,
   input  wire logic             out_ready,
   output      logic [WIDTH-1:0] out_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push;
   logic             pop;

   assign in_ready  = count_ff != CNT_W'(DEPTH);
   assign out_valid = count_ff != '0;
   assign out_data  = mem_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

`default_nettype wire

>>> sv/esm_front.sv
`default_nettype none

module esm_front #(
   parameter int PIXEL_COUNT_BITS = 24
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   esm_pixel_if.sink                        pix,
   output      logic                        frame_valid,
   input  wire logic                        frame_ready,
   output      logic [esm_pkg::SUM_W-1:0]   frame_sum,
   output      logic [PIXEL_COUNT_BITS-1:0] frame_count
);

   localparam logic [PIXEL_COUNT_BITS-1:0] COUNT_MAX = '1;

   logic                        s1_valid_ff, s1_valid_in;
   logic                        s1_last_ff;
   logic [esm_pkg::LUMA_W-1:0]  s1_luma_ff;
   logic [esm_pkg::SUM_W-1:0]   sum_ff, sum_in;
   logic [PIXEL_COUNT_BITS-1:0] count_ff, count_in;
   logic [esm_pkg::SUM_W:0]     sum_wide;
   logic [esm_pkg::SUM_W-1:0]   sum_next;
   logic [PIXEL_COUNT_BITS-1:0] count_next;
   logic                        s1_drain;
   logic                        accept;

   assign s1_drain    = s1_valid_ff && (!s1_last_ff || frame_ready);
   assign pix.ready   = !s1_valid_ff || s1_drain;
   assign accept      = pix.valid && pix.ready;
   assign frame_valid = s1_valid_ff && s1_last_ff;
   assign frame_sum   = sum_next;
   assign frame_count = count_next;

   always_comb begin
      sum_wide   = {1'b0, sum_ff} + (esm_pkg::SUM_W + 1)'(s1_luma_ff);
      sum_next   = sum_ff;
      count_next = count_ff;
      if (count_ff != COUNT_MAX) begin
         sum_next   = sum_wide[esm_pkg::SUM_W] ? '1 : sum_wide[esm_pkg::SUM_W-1:0];
         count_next = count_ff + 1'b1;
      end
      sum_in   = sum_ff;
      count_in = count_ff;
      if (s1_drain) begin
         sum_in   = s1_last_ff ? '0 : sum_next;
         count_in = s1_last_ff ? '0 : count_next;
      end
      s1_valid_in = accept || (s1_valid_ff && !s1_drain);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         sum_ff      <= '0;
         count_ff    <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         sum_ff      <= sum_in;
         count_ff    <= count_in;
      end
      if (accept) begin
         s1_luma_ff <= esm_pkg::luma_of(pix.blue, pix.green, pix.red);
         s1_last_ff <= pix.last_pixel;
      end
   end

endmodule

`default_nettype wire

>>> sv/esm_back.sv
`default_nettype none

module esm_back #(
   parameter int WINDOW_MAX       = 128,
   parameter int PIXEL_COUNT_BITS = 24
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire esm_pkg::csr_type            csr,
   input  wire logic                        job_valid,
   output      logic                        job_ready,
   input  wire logic [esm_pkg::SUM_W-1:0]   job_sum,
   input  wire logic [PIXEL_COUNT_BITS-1:0] job_count,
   esm_result_if.source                     res
);

   localparam int ADDR_W = $clog2(WINDOW_MAX);
   localparam int FILL_W = $clog2(WINDOW_MAX + 1);
   localparam int CMP_W  = ((FILL_W > 8) ? FILL_W : 8) + 1;
   localparam int REM_W  = PIXEL_COUNT_BITS + 1;
   localparam int MEAN_W = esm_pkg::MEAN_W;
   localparam int STEP_W = $clog2(MEAN_W);
   localparam int FRAC_W = esm_pkg::FRAC_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_WRITE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   state_type                       state_ff, state_in;
   logic [REM_W-1:0]                rem_ff, rem_in;
   logic [PIXEL_COUNT_BITS-1:0]     divisor_ff, divisor_in;
   logic [MEAN_W-1:0]               quo_ff, quo_in;
   logic [STEP_W-1:0]               step_ff, step_in;
   logic [ADDR_W-1:0]               head_ff, head_in;
   logic [FILL_W-1:0]               fill_ff, fill_in;
   logic [ADDR_W-1:0]               rd_ptr_ff, rd_ptr_in;
   logic [FILL_W-1:0]               rd_left_ff, rd_left_in;
   logic                            pend_ff, pend_in;
   logic [MEAN_W-1:0]               lo_ff, lo_in;
   logic [MEAN_W-1:0]               hi_ff, hi_in;
   logic                            test_ff, test_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [MEAN_W-1:0]               rsp_mean_ff, rsp_mean_in;
   logic                            rsp_adj_ff, rsp_adj_in;
   logic [esm_pkg::FILL_OUT_W-1:0]  rsp_fill_ff, rsp_fill_in;

   logic [REM_W-1:0]  trial;
   logic              trial_ge;
   logic [CMP_W-1:0]  wl_ext;
   logic [CMP_W-1:0]  eff_len;
   logic [CMP_W-1:0]  fill_inc;
   logic [CMP_W-1:0]  fill_new;
   logic [CMP_W-1:0]  need;
   logic              wr_en;
   logic              rd_en;
   logic [MEAN_W-1:0] rd_data;

   esm_ram #(
      .WIDTH(MEAN_W),
      .DEPTH(WINDOW_MAX)
   ) u_window_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(head_ff),
      .wr_data(quo_ff),
      .rd_en  (rd_en),
      .rd_addr(rd_ptr_ff),
      .rd_data(rd_data)
   );

   assign job_ready       = state_ff == ST_IDLE;
   assign res.valid       = rsp_valid_ff;
   assign res.mean_luma   = rsp_mean_ff;
   assign res.adjusting   = rsp_adj_ff;
   assign res.window_fill = rsp_fill_ff;

   always_comb begin
      trial    = {rem_ff[REM_W-2:0], quo_ff[MEAN_W-1]};
      trial_ge = trial >= {1'b0, divisor_ff};

      wl_ext = CMP_W'(csr.window_length);
      if (wl_ext == '0) begin
         eff_len = CMP_W'(1);
      end else if (wl_ext > CMP_W'(WINDOW_MAX)) begin
         eff_len = CMP_W'(WINDOW_MAX);
      end else begin
         eff_len = wl_ext;
      end
      fill_inc = CMP_W'(fill_ff) + 1'b1;
      fill_new = (fill_inc > eff_len) ? eff_len : fill_inc;
      need     = (csr.min_samples == '0) ? CMP_W'(1) : CMP_W'(csr.min_samples);

      state_in     = state_ff;
      rem_in       = rem_ff;
      divisor_in   = divisor_ff;
      quo_in       = quo_ff;
      step_in      = step_ff;
      head_in      = head_ff;
      fill_in      = fill_ff;
      rd_ptr_in    = rd_ptr_ff;
      rd_left_in   = rd_left_ff;
      pend_in      = 1'b0;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      test_in      = test_ff;
      rsp_valid_in = rsp_valid_ff && !res.ready;
      rsp_mean_in  = rsp_mean_ff;
      rsp_adj_in   = rsp_adj_ff;
      rsp_fill_in  = rsp_fill_ff;
      wr_en        = 1'b0;
      rd_en        = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               rem_in     = REM_W'(job_sum[esm_pkg::SUM_W-1:FRAC_W]);
               quo_in     = {job_sum[FRAC_W-1:0], FRAC_W'(0)};
               divisor_in = job_count;
               step_in    = '0;
               state_in   = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            rem_in  = trial_ge ? trial - {1'b0, divisor_ff} : trial;
            quo_in  = {quo_ff[MEAN_W-2:0], trial_ge};
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(MEAN_W - 1)) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            wr_en      = 1'b1;
            head_in    = (head_ff == ADDR_W'(WINDOW_MAX - 1)) ? '0 : head_ff + 1'b1;
            rd_ptr_in  = (head_ff == '0) ? ADDR_W'(WINDOW_MAX - 1) : head_ff - 1'b1;
            fill_in    = FILL_W'(fill_new);
            rd_left_in = FILL_W'(fill_new) - 1'b1;
            lo_in      = quo_ff;
            hi_in      = quo_ff;
            test_in    = fill_new >= need;
            state_in   = (fill_new >= need) ? ST_SCAN : ST_FINISH;
         end
         ST_SCAN: begin
            if (rd_left_ff != '0) begin
               rd_en      = 1'b1;
               pend_in    = 1'b1;
               rd_left_in = rd_left_ff - 1'b1;
               rd_ptr_in  = (rd_ptr_ff == '0) ? ADDR_W'(WINDOW_MAX - 1) : rd_ptr_ff - 1'b1;
            end else if (!pend_ff) begin
               state_in = ST_FINISH;
            end
            if (pend_ff) begin
               if (rd_data < lo_ff) begin
                  lo_in = rd_data;
               end
               if (rd_data > hi_ff) begin
                  hi_in = rd_data;
               end
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || res.ready) begin
               rsp_valid_in = 1'b1;
               rsp_mean_in  = quo_ff;
               rsp_adj_in   = test_ff && ((hi_ff - lo_ff) > csr.range_threshold);
               rsp_fill_in  = (CMP_W'(fill_ff) > CMP_W'(255)) ? '1
                                                               : esm_pkg::FILL_OUT_W'(fill_ff);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         fill_ff      <= '0;
         rd_left_ff   <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         fill_ff      <= fill_in;
         rd_left_ff   <= rd_left_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff      <= rem_in;
      divisor_ff  <= divisor_in;
      quo_ff      <= quo_in;
      step_ff     <= step_in;
      rd_ptr_ff   <= rd_ptr_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      test_ff     <= test_in;
      rsp_mean_ff <= rsp_mean_in;
      rsp_adj_ff  <= rsp_adj_in;
      rsp_fill_ff <= rsp_fill_in;
   end

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(WINDOW_MAX))
      else $error("window fill beyond window size");

   a_head_bound: assert property (@(posedge clock) disable iff (reset)
      head_ff <= ADDR_W'(WINDOW_MAX - 1))
      else $error("window head out of range");

   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIVIDE |-> rem_ff < {1'b0, divisor_ff})
      else $error("divider remainder not below divisor");

   a_mean_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_mean_ff <= 16'hFF00)
      else $error("frame mean above full scale");

   a_read_in_scan: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> $past(state_ff) == ST_SCAN)
      else $error("window read outside scan");

endmodule

`default_nettype wire

>>> sv/exposure_stability_monitor.sv
// Channel   Direction  Payload                                    Transfer
// req_if    in         blue, green, red, last_pixel               valid && ready
// rsp_if    out        mean_luma, adjusting, window_fill          valid && ready
// csr_*     in         csr_index, csr_wr_data                     csr_wr_en
//
// Pixels are taken one per cycle while req_if.ready is high; a transfer on rsp_if follows only a last pixel.
// Each frame then passes through a start state, the divider, one window write,
// window_fill - 1 window memory reads and the end of the scan and the loading of the
// result; the window reads are left out when the range test is skipped.
// A two-frame queue sits between the pixel path and the per-frame unit, so pixel
// intake stalls only when frames come faster than the per-frame unit ends them or while a
// result waits on rsp_if.
// Reset is synchronous and clears the frame sum, count, window head and fill.
`default_nettype none

module exposure_stability_monitor #(
   parameter int WINDOW_MAX       = 128,
   parameter int PIXEL_COUNT_BITS = 24
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   esm_pixel_if.sink                             req_if,
   esm_result_if.source                          rsp_if,
   input  wire logic                             csr_wr_en,
   input  wire logic [esm_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [esm_pkg::CSR_DATA_W-1:0]   csr_wr_data
);

   localparam int JOB_W = esm_pkg::SUM_W + PIXEL_COUNT_BITS;

   esm_pkg::csr_type            csr_ff, csr_in;
   logic                        frame_valid;
   logic                        frame_ready;
   logic [esm_pkg::SUM_W-1:0]   frame_sum;
   logic [PIXEL_COUNT_BITS-1:0] frame_count;
   logic                        job_valid;
   logic                        job_ready;
   logic [JOB_W-1:0]            job_data;

   always_comb begin
      csr_in = csr_ff;
      if (csr_wr_en) begin
         case (csr_index)
            esm_pkg::CSR_WINDOW_LENGTH:   csr_in.window_length   = csr_wr_data[7:0];
            esm_pkg::CSR_MIN_SAMPLES:     csr_in.min_samples     = csr_wr_data[7:0];
            esm_pkg::CSR_RANGE_THRESHOLD: csr_in.range_threshold = csr_wr_data;
            default: csr_in = csr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.window_length   <= esm_pkg::WINDOW_LENGTH_RESET;
         csr_ff.min_samples     <= esm_pkg::MIN_SAMPLES_RESET;
         csr_ff.range_threshold <= esm_pkg::RANGE_THRESHOLD_RESET;
      end else begin
         csr_ff <= csr_in;
      end
   end

   esm_front #(
      .PIXEL_COUNT_BITS(PIXEL_COUNT_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .pix        (req_if),
      .frame_valid(frame_valid),
      .frame_ready(frame_ready),
      .frame_sum  (frame_sum),
      .frame_count(frame_count)
   );

   esm_queue #(
      .WIDTH(JOB_W),
      .DEPTH(2)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .in_valid (frame_valid),
      .in_ready (frame_ready),
      .in_data  ({frame_sum, frame_count}),
      .out_valid(job_valid),
      .out_ready(job_ready),
      .out_data (job_data)
   );

   esm_back #(
      .WINDOW_MAX      (WINDOW_MAX),
      .PIXEL_COUNT_BITS(PIXEL_COUNT_BITS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .csr      (csr_ff),
      .job_valid(job_valid),
      .job_ready(job_ready),
      .job_sum  (job_data[JOB_W-1:PIXEL_COUNT_BITS]),
      .job_count(job_data[PIXEL_COUNT_BITS-1:0]),
      .res      (rsp_if)
   );

endmodule

`default_nettype wire

>>> bench/exposure_stability_monitor_tb.sv
`timescale 1ns / 1ps

module exposure_stability_monitor_tb;

   localparam int          ITEM_TARGET   = 750;
   localparam int          SETTLE_CYCLES = 200;
   localparam int          QUIET_LIMIT   = 4000;
   localparam int          HISTORY_DEPTH = 128;
   localparam int          DUE_DEPTH     = 16;
   localparam logic [23:0] COUNT_CEILING = 24'hFF_FFFF;

   typedef struct packed {
      logic [15:0] mean_luma;
      logic        adjusting;
      logic [7:0]  window_fill;
   } frame_stats_type;

   logic                           clock;
   logic                           reset;
   logic                           csr_wr_en;
   logic [esm_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [esm_pkg::CSR_DATA_W-1:0] csr_wr_data;

   esm_pixel_if  req_bus ();
   esm_result_if rsp_bus ();

   exposure_stability_monitor i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_bus),
      .rsp_if      (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   esm_pkg::csr_type settings;
   logic [31:0]      frame_sum;
   logic [23:0]      frame_count;
   logic [15:0]      history [HISTORY_DEPTH];
   logic [6:0]       history_head;
   int               history_fill;
   frame_stats_type  due_list [DUE_DEPTH];
   frame_stats_type  arrived_stats;

   int mismatches   = 0;
   int pixels_sent  = 0;
   int stall_left   = 0;
   int quiet_cycles = 0;
   int due_pushed   = 0;
   int due_popped   = 0;
   bit steady_flow  = 1'b0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic int draw_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 70) return 0;
      if (roll < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [7:0] luma_of_pixel(input logic [7:0] b, g, r);
      int unsigned weighted;
      weighted = 32'd1868 * b + 32'd9617 * g + 32'd4899 * r + 32'd8192;
      return 8'(weighted >> 14);
   endfunction

   // Accumulates one accepted pixel and, on the last pixel of a frame, queues the
   // statistics that the frame should produce.
   function automatic void record_pixel(input logic [7:0] b, g, r, input logic last_pixel);
      logic [32:0]     widened;
      logic [63:0]     quotient;
      logic [6:0]      slot;
      int              span, need, lo, hi, i;
      frame_stats_type stats;
      if (frame_count < COUNT_CEILING) begin
         widened     = {1'b0, frame_sum} + luma_of_pixel(b, g, r);
         frame_sum   = widened[32] ? 32'hFFFF_FFFF : widened[31:0];
         frame_count = frame_count + 1'b1;
      end
      if (!last_pixel) return;
      quotient = (frame_count == 0) ? 64'd0 : ({32'd0, frame_sum} << 8) / frame_count;
      stats.mean_luma = (quotient > 64'hFFFF) ? 16'hFFFF : quotient[15:0];
      history[history_head] = stats.mean_luma;
      history_head = history_head + 1'b1;
      if (settings.window_length == 0) span = 1;
      else if (settings.window_length > HISTORY_DEPTH) span = HISTORY_DEPTH;
      else span = int'(settings.window_length);
      history_fill = (history_fill + 1 > span) ? span : history_fill + 1;
      need = (settings.min_samples == 0) ? 1 : int'(settings.min_samples);
      stats.adjusting = 1'b0;
      if (history_fill >= need) begin
         lo = 'hFFFF;
         hi = 0;
         for (i = 0; i < history_fill; i++) begin
            slot = history_head - 7'(i + 1);
            if (int'(history[slot]) < lo) lo = int'(history[slot]);
            if (int'(history[slot]) > hi) hi = int'(history[slot]);
         end
         stats.adjusting = (hi - lo) > int'(settings.range_threshold);
      end
      stats.window_fill = 8'(history_fill);
      due_list[due_pushed[3:0]] = stats;
      due_pushed++;
      frame_sum   = '0;
      frame_count = '0;
   endfunction

   task automatic send_pixel(input logic [7:0] b, g, r, input logic last_pixel);
      int gap;
      gap = steady_flow ? 0 : draw_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.blue       <= b;
      req_bus.green      <= g;
      req_bus.red        <= r;
      req_bus.last_pixel <= last_pixel;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      record_pixel(b, g, r, last_pixel);
      pixels_sent++;
   endtask

   task automatic settle();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (due_pushed != due_popped) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [esm_pkg::CSR_IDX_W-1:0] index,
                            input logic [15:0] data);
      csr_wr_en   <= 1'b1;
      csr_index   <= index;
      csr_wr_data <= data;
      @(posedge clock);
   endtask

   task automatic apply_config(input logic [7:0] span, input logic [7:0] need,
                               input logic [15:0] limit);
      settle();
      write_csr(esm_pkg::CSR_WINDOW_LENGTH, {8'($urandom), span});
      write_csr(esm_pkg::CSR_MIN_SAMPLES, {8'($urandom), need});
      write_csr(esm_pkg::CSR_RANGE_THRESHOLD, limit);
      csr_wr_en <= 1'b0;
      settings = {span, need, limit};
   endtask

   // Frames of a scene whose brightness drifts slowly, with an occasional cut.
   task automatic play_scene(input int frames, input int max_len, input int spread);
      int         level, len, roll, f, p;
      logic [7:0] lo, hi;
      level = $urandom_range(0, 255);
      for (f = 0; f < frames; f++) begin
         if ($urandom_range(0, 19) == 0) level = $urandom_range(0, 255);
         else level = level + int'($urandom_range(0, 6)) - 3;
         if (level < 0) level = 0;
         if (level > 255) level = 255;
         roll = $urandom_range(0, 99);
         if (roll < 75) len = $urandom_range(1, 4);
         else if (roll < 97) len = $urandom_range(5, 24);
         else len = $urandom_range(60, 150);
         if (len > max_len) len = max_len;
         lo = (spread >= 255) ? 8'd0 : 8'(level);
         hi = (level + spread > 255) ? 8'd255 : 8'(level + spread);
         for (p = 1; p <= len; p++)
            send_pixel(8'($urandom_range(hi, lo)), 8'($urandom_range(hi, lo)),
                       8'($urandom_range(hi, lo)), p == len);
      end
   endtask

   task automatic test_reset_settings();
      send_pixel(8'd0, 8'd0, 8'd0, 1'b1);
      send_pixel(8'd255, 8'd255, 8'd255, 1'b1);
      send_pixel(8'd255, 8'd0, 8'd0, 1'b0);
      send_pixel(8'd0, 8'd255, 8'd0, 1'b0);
      send_pixel(8'd0, 8'd0, 8'd255, 1'b1);
   endtask

   task automatic test_channel_extremes();
      apply_config(8'd3, 8'd1, 16'd0);
      send_pixel(8'd0, 8'd0, 8'd0, 1'b1);
      send_pixel(8'd255, 8'd0, 8'd0, 1'b1);
      send_pixel(8'd0, 8'd255, 8'd0, 1'b1);
      send_pixel(8'd0, 8'd0, 8'd255, 1'b1);
      send_pixel(8'd255, 8'd255, 8'd255, 1'b1);
      apply_config(8'd3, 8'd1, 16'd65279);
      send_pixel(8'd0, 8'd0, 8'd0, 1'b1);
      send_pixel(8'd255, 8'd255, 8'd255, 1'b1);
   endtask

   task automatic test_window_corners();
      apply_config(8'd0, 8'd0, 16'd0);
      send_pixel(8'd128, 8'd64, 8'd32, 1'b0);
      send_pixel(8'd7, 8'd200, 8'd99, 1'b1);
      send_pixel(8'd255, 8'd255, 8'd255, 1'b1);
      send_pixel(8'd1, 8'd2, 8'd3, 1'b1);
      apply_config(8'd255, 8'd200, 16'hFFFF);
      send_pixel(8'd170, 8'd85, 8'd170, 1'b1);
      send_pixel(8'd85, 8'd170, 8'd85, 1'b1);
      send_pixel(8'd0, 8'd0, 8'd0, 1'b1);
   endtask

   task automatic test_full_window();
      apply_config(8'd128, 8'd128, 16'($urandom_range(500, 6000)));
      play_scene(150, 1, 12);
   endtask

   task automatic test_window_resize();
      apply_config(8'd5, 8'd6, 16'($urandom_range(0, 3000)));
      play_scene(8, 2, 20);
      apply_config(8'd40, 8'd3, 16'd0);
      play_scene(45, 2, 8);
      apply_config(8'd1, 8'd1, 16'd0);
      play_scene(4, 3, 255);
   endtask

   task automatic test_random_settings();
      logic [7:0]  span, need;
      logic [15:0] limit;
      int          roll, spread;
      while (pixels_sent < ITEM_TARGET) begin
         roll = $urandom_range(0, 9);
         if (roll == 0) span = 8'd0;
         else if (roll == 1) span = 8'd1;
         else if (roll == 2) span = 8'd128;
         else if (roll == 3) span = 8'($urandom_range(129, 255));
         else span = 8'($urandom_range(2, 64));
         roll = $urandom_range(0, 9);
         if (roll == 0) need = 8'd0;
         else if (roll == 1) need = 8'd1;
         else if (roll == 2) need = (span >= 8'd128) ? 8'd129 : span + 8'd1;
         else need = 8'($urandom_range(1, 20));
         roll = $urandom_range(0, 9);
         if (roll == 0) limit = 16'd0;
         else if (roll == 1) limit = 16'hFFFF;
         else limit = 16'($urandom_range(0, 12000));
         roll = $urandom_range(0, 3);
         if (roll == 0) spread = $urandom_range(0, 4);
         else if (roll == 1) spread = 12;
         else if (roll == 2) spread = 40;
         else spread = 255;
         apply_config(span, need, limit);
         steady_flow = ($urandom_range(0, 3) == 0);
         play_scene($urandom_range(8, 30), 150, spread);
         steady_flow = 1'b0;
      end
   endtask

   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left    <= stall_left - 1;
      end else if (!steady_flow && $urandom_range(0, 3) == 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left    <= draw_gap();
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (due_pushed == due_popped) begin
            $error("unexpected result transfer: mean_luma %0d", rsp_bus.mean_luma);
            mismatches++;
         end else begin
            arrived_stats = due_list[due_popped[3:0]];
            due_popped++;
            if (rsp_bus.mean_luma !== arrived_stats.mean_luma) begin
               $error("mean_luma: expected %0d, actual %0d",
                      arrived_stats.mean_luma, rsp_bus.mean_luma);
               mismatches++;
            end
            if (rsp_bus.adjusting !== arrived_stats.adjusting) begin
               $error("adjusting: expected %0d, actual %0d",
                      arrived_stats.adjusting, rsp_bus.adjusting);
               mismatches++;
            end
            if (rsp_bus.window_fill !== arrived_stats.window_fill) begin
               $error("window_fill: expected %0d, actual %0d",
                      arrived_stats.window_fill, rsp_bus.window_fill);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset              = 1'b1;
      csr_wr_en          = 1'b0;
      csr_index          = '0;
      csr_wr_data        = '0;
      req_bus.valid      = 1'b0;
      req_bus.blue       = '0;
      req_bus.green      = '0;
      req_bus.red        = '0;
      req_bus.last_pixel = 1'b0;
      settings     = {esm_pkg::WINDOW_LENGTH_RESET, esm_pkg::MIN_SAMPLES_RESET,
                      esm_pkg::RANGE_THRESHOLD_RESET};
      frame_sum    = '0;
      frame_count  = '0;
      history_head = '0;
      history_fill = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_reset_settings();
      test_channel_extremes();
      test_window_corners();
      test_full_window();
      test_window_resize();
      test_random_settings();
      settle();
      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
